>>> rtl/paging_frame_allocator_macros.svh
// Assertion helpers used by the allocator RTL
`ifndef PAGING_FRAME_ALLOCATOR_MACROS_SVH
`define PAGING_FRAME_ALLOCATOR_MACROS_SVH

// Property checked on every clock edge outside reset
`define PFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent required in the cycle after the antecedent
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

	localparam int DATA_W    = 24;
	localparam int OWNER_W   = 16;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int ID_MAX_W  = 32;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_ID_WIDTH    = 16;

	localparam int RST_MEM_BYTES_I   = 65536;
	localparam int RST_FRAME_BYTES_I = 4096;

	localparam logic [DATA_W-1:0] RST_MEM_BYTES   = DATA_W'(RST_MEM_BYTES_I);
	localparam logic [DATA_W-1:0] RST_FRAME_BYTES = DATA_W'(RST_FRAME_BYTES_I);
	localparam logic [DATA_W-1:0] RST_FREE_FRAMES =
		DATA_W'(RST_MEM_BYTES_I / RST_FRAME_BYTES_I);

	localparam logic [CFG_IDX_W-1:0] REG_MEM_BYTES   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = CFG_IDX_W'(1);

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_MEM_FULL    = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_INSUFF      = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = STATUS_W'(4);

	typedef struct packed {
		logic                done;
		logic [DATA_W-1:0]   quo;
		logic [DATA_W-1:0]   rem;
	} div_res_t;

endpackage

`default_nettype wire

>>> rtl/pfa_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle; a new start aborts any division in flight
module pfa_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pfa_pkg::DATA_W-1:0] dividend,
	input  wire logic [pfa_pkg::DATA_W-1:0] divisor,
	output pfa_pkg::div_res_t               res
);

	localparam int W     = pfa_pkg::DATA_W;
	localparam int CNT_W = $clog2(W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;

	logic [W:0]       trial;
	logic [W+1:0]     diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		ge    = !diff[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && cnt_q == LAST_STEP;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

>>> rtl/paging_frame_allocator.sv
// Allocate: the result follows the divide and the decision, or the divide is skipped
// when no frame is free or the frame size is zero.
// Free: entries are scanned from entry 0 up to a hit or the last entry (one entry read a cycle).
// One request at a time; a new request is taken once the previous one has reached the output.
// Reset loads the register defaults and an empty table at once; a write to a known register empties
// the table and blocks requests while the free count is recomputed by the divider.
`default_nettype none

`include "paging_frame_allocator_macros.svh"

module paging_frame_allocator #(
	parameter int TABLE_DEPTH = pfa_pkg::DEF_TABLE_DEPTH,
	parameter int ID_WIDTH    = pfa_pkg::DEF_ID_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          req_type,
	input  wire logic [pfa_pkg::OWNER_W-1:0]   owner_id,
	input  wire logic [pfa_pkg::DATA_W-1:0]    req_bytes,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [pfa_pkg::STATUS_W-1:0]       status,
	output logic [pfa_pkg::DATA_W-1:0]         frames_changed,
	output logic [pfa_pkg::DATA_W-1:0]         frames_free,

	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pfa_pkg::DATA_W-1:0]    cfg_data
);

	localparam int DW    = pfa_pkg::DATA_W;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = ID_WIDTH + DW;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RELOAD = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0]                      state_q;
	logic [DW-1:0]                   mem_bytes_q;
	logic [DW-1:0]                   frame_bytes_q;
	logic [DW-1:0]                   free_q;
	logic [CNT_W-1:0]                count_q;
	logic [ID_WIDTH-1:0]             key_q;
	logic [CNT_W-1:0]                scan_addr_q;
	logic                            rl_start_q;
	logic [pfa_pkg::STATUS_W-1:0]    res_status_q;
	logic [DW-1:0]                   res_changed_q;
	logic                            out_valid_q;
	logic [pfa_pkg::STATUS_W-1:0]    out_status_q;
	logic [DW-1:0]                   out_changed_q;
	logic [DW-1:0]                   out_free_q;

	logic                            rd_vld_s1;
	logic [IDX_W-1:0]                rd_idx_s1;
	logic [ENT_W-1:0]                rd_data_s1;

	logic [ENT_W-1:0]                entry_mem [TABLE_DEPTH];

	logic [pfa_pkg::ID_MAX_W-1:0]    id_ext;
	logic [ID_WIDTH-1:0]             key;
	logic                            in_accept;
	logic                            cfg_wr;
	logic                            cfg_known;
	logic                            slot_free;
	logic                            out_load;
	logic                            div_start;
	logic [DW-1:0]                   div_dividend;
	pfa_pkg::div_res_t               div_res;
	logic [DW-1:0]                   need;
	logic [ID_WIDTH-1:0]             rd_owner;
	logic [DW-1:0]                   rd_frames;
	logic                            hit;
	logic                            last;
	logic                            alloc_ok;
	logic                            mem_re;
	logic [IDX_W-1:0]                mem_raddr;
	logic                            mem_we;
	logic [IDX_W-1:0]                mem_waddr;
	logic [ENT_W-1:0]                mem_wdata;

	assign id_ext    = pfa_pkg::ID_MAX_W'(owner_id);
	assign key       = id_ext[ID_WIDTH-1:0];
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_known = cfg_index inside {pfa_pkg::REG_MEM_BYTES, pfa_pkg::REG_FRAME_BYTES};
	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = !cfg_wr && state_q == S_FIN && slot_free;

	// An allocate divides only when the quick memory-full check passes; a reload also divides
	assign div_start = rl_start_q || (in_accept && req_type == pfa_pkg::REQ_ALLOC &&
		free_q != '0 && frame_bytes_q != '0);
	assign div_dividend = (state_q == S_RELOAD) ? mem_bytes_q : req_bytes;

	pfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (frame_bytes_q),
		.res      (div_res)
	);

	// Round up; a nonzero remainder implies a divisor of two or more, so no overflow
	assign need = div_res.quo + DW'(div_res.rem != '0);

	assign rd_owner  = rd_data_s1[ENT_W-1 -: ID_WIDTH];
	assign rd_frames = rd_data_s1[DW-1:0];
	assign hit  = rd_vld_s1 && rd_owner == key_q && rd_frames != '0;
	assign last = rd_vld_s1 && (CNT_W'(rd_idx_s1) + CNT_W'(1)) == count_q;
	assign alloc_ok = div_res.done && need <= free_q && count_q < DEPTH_CNT;

	assign mem_re    = (state_q == S_SCAN) && scan_addr_q < count_q;
	assign mem_raddr = scan_addr_q[IDX_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = {key_q, need};
		if (state_q == S_DIV && alloc_ok) begin
			mem_we = 1'b1;
		end else if (state_q == S_SCAN && hit) begin
			// mark dead: keep the owner, clear the frames
			mem_we    = 1'b1;
			mem_waddr = rd_idx_s1;
			mem_wdata = {rd_owner, DW'(0)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= entry_mem[mem_raddr];
		end
		rd_idx_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mem_bytes_q   <= pfa_pkg::RST_MEM_BYTES;
			frame_bytes_q <= pfa_pkg::RST_FRAME_BYTES;
			free_q        <= pfa_pkg::RST_FREE_FRAMES;
			count_q       <= '0;
			key_q         <= '0;
			scan_addr_q   <= '0;
			rl_start_q    <= 1'b0;
			res_status_q  <= pfa_pkg::ST_OK;
			res_changed_q <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= pfa_pkg::ST_OK;
			out_changed_q <= '0;
			out_free_q    <= '0;
			rd_vld_s1     <= 1'b0;
		end else begin
			rl_start_q <= cfg_wr && cfg_known;
			rd_vld_s1  <= mem_re;
			// hold the result until the output register is free
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_status_q  <= res_status_q;
				out_changed_q <= res_changed_q;
				out_free_q    <= free_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (cfg_index == pfa_pkg::REG_MEM_BYTES) begin
					mem_bytes_q <= cfg_data;
				end
				if (cfg_index == pfa_pkg::REG_FRAME_BYTES) begin
					frame_bytes_q <= cfg_data;
				end
				if (cfg_known) begin
					count_q <= '0;
					state_q <= S_RELOAD;
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_accept) begin
							key_q         <= key;
							res_changed_q <= '0;
							if (req_type == pfa_pkg::REQ_FREE) begin
								scan_addr_q <= '0;
								if (count_q == '0) begin
									res_status_q <= pfa_pkg::ST_NOT_FOUND;
									state_q      <= S_FIN;
								end else begin
									state_q <= S_SCAN;
								end
							end else if (free_q == '0 || frame_bytes_q == '0) begin
								res_status_q <= pfa_pkg::ST_MEM_FULL;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_DIV;
							end
						end
					end
					S_RELOAD: begin
						if (div_res.done && !rl_start_q) begin
							free_q  <= (frame_bytes_q == '0) ? '0 : div_res.quo;
							state_q <= S_IDLE;
						end
					end
					S_DIV: begin
						if (div_res.done) begin
							state_q <= S_FIN;
							if (need > free_q) begin
								res_status_q <= pfa_pkg::ST_INSUFF;
							end else if (count_q >= DEPTH_CNT) begin
								res_status_q <= pfa_pkg::ST_TABLE_FULL;
							end else begin
								res_status_q  <= pfa_pkg::ST_OK;
								res_changed_q <= need;
								free_q        <= free_q - need;
								count_q       <= count_q + CNT_W'(1);
							end
						end
					end
					S_SCAN: begin
						if (mem_re) begin
							scan_addr_q <= scan_addr_q + CNT_W'(1);
						end
						if (hit) begin
							res_status_q  <= pfa_pkg::ST_OK;
							res_changed_q <= rd_frames;
							free_q        <= free_q + rd_frames;
							state_q       <= S_FIN;
						end else if (last) begin
							res_status_q <= pfa_pkg::ST_NOT_FOUND;
							state_q      <= S_FIN;
						end
					end
					S_FIN: begin
						if (slot_free) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign frames_changed = out_changed_q;
	assign frames_free    = out_free_q;

	`PFA_ASSERT(a_count_bound, count_q <= DEPTH_CNT, "entry count beyond table depth")
	`PFA_ASSERT(a_err_no_frames, !(out_valid_q && out_status_q != pfa_pkg::ST_OK) || out_changed_q == '0, "error transaction reports frames")
	`PFA_ASSERT_NEXT(a_fin_delivers, state_q == S_FIN && slot_free && !cfg_valid, out_valid_q && state_q == S_IDLE, "finished request not presented")
	`PFA_ASSERT(a_scan_nonempty, state_q != S_SCAN || count_q != '0, "scan of an empty table")

endmodule

`default_nettype wire
